// File: design/bc1_block_decoder_defines.svh
// ----------------------------------------------------------------------------
// BC1 block decoder assertion macros
// Shared concurrent-check forms, clocked on clk and held off by rst_n.
// ----------------------------------------------------------------------------
`ifndef BC1_BLOCK_DECODER_DEFINES_SVH
`define BC1_BLOCK_DECODER_DEFINES_SVH

// same-cycle implication
`define BC1_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BC1_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/bc1_pkg.sv
// ----------------------------------------------------------------------------
// BC1 block decoder package
// Shared widths, limits, queue entry type and the divide-by-three helper.
// ----------------------------------------------------------------------------
package bc1_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int CFG_W   = 13;
  localparam int COL_W   = 10;
  localparam int COORD_W = 12;
  localparam int COLOR_W = 16;
  localparam int IDX_W   = 32;

  localparam int BPR_LIM_I = (MAX_WIDTH / 4 > 1024) ? 1024 :
                             ((MAX_WIDTH / 4 < 1) ? 1 : MAX_WIDTH / 4);
  localparam int ROW_LIM_I = (MAX_HEIGHT / 4 > 1024) ? 1024 :
                             ((MAX_HEIGHT / 4 < 1) ? 1 : MAX_HEIGHT / 4);

  localparam logic [COL_W:0] BPR_LIM = (COL_W + 1)'(BPR_LIM_I);
  localparam logic [COL_W:0] ROW_LIM = (COL_W + 1)'(ROW_LIM_I);

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST = CFG_W'(4);

  localparam logic [1:0] SEL_CLEAR = 2'd3;
  localparam logic [3:0] PIX_LAST  = 4'd15;

  typedef struct packed {
    logic [3:0][COLOR_W-1:0] pal;
    logic                    four;
    logic [IDX_W-1:0]        idx;
    logic [COL_W-1:0]        col;
    logic [COL_W-1:0]        row;
  } blk_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  // truncating v/3 for any 8-bit v, as (v*171)>>9
  function automatic logic [6:0] div3(input logic [7:0] v);
    logic [16:0] prod;
    prod = {9'd0, v} * 17'd171;
    return prod[15:9];
  endfunction

endpackage

// File: design/bc1_front.sv
// ----------------------------------------------------------------------------
// BC1 front end
// Takes blocks, builds the four-entry palette, tracks the block position and
// holds the image width register. Writes one queue entry per block.
// ----------------------------------------------------------------------------
module bc1_front import bc1_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [63:0]      in_block_word,
  input  logic             in_last_block,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_image_width,
  input  q_stat_t          q_stat,
  output logic             push,
  output blk_t             push_blk
);

  logic [CFG_W-1:0] image_width_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [COL_W-1:0] row_r, row_nxt;

  logic [15:0] c0, c1;
  logic [4:0]  r0, r1, b0, b1;
  logic [5:0]  g0, g1;
  logic        four;
  logic [6:0]  r2, g2, b2, r3, g3, b3;
  logic [5:0]  r_sum, b_sum;
  logic [6:0]  g_sum;
  logic [COL_W:0] bw, bpr, col_inc, row_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_stat.full;
  assign push      = in_valid && !q_stat.full;

  assign c0 = in_block_word[15:0];
  assign c1 = in_block_word[31:16];
  assign r0 = c0[15:11];
  assign g0 = c0[10:5];
  assign b0 = c0[4:0];
  assign r1 = c1[15:11];
  assign g1 = c1[10:5];
  assign b1 = c1[4:0];
  assign four = c0 > c1;

  assign r2 = div3({2'b00, r0, 1'b0} + {3'b000, r1});
  assign g2 = div3({1'b0, g0, 1'b0} + {2'b00, g1});
  assign b2 = div3({2'b00, b0, 1'b0} + {3'b000, b1});
  assign r3 = div3({3'b000, r0} + {2'b00, r1, 1'b0});
  assign g3 = div3({2'b00, g0} + {1'b0, g1, 1'b0});
  assign b3 = div3({3'b000, b0} + {2'b00, b1, 1'b0});

  assign r_sum = {1'b0, r0} + {1'b0, r1};
  assign g_sum = {1'b0, g0} + {1'b0, g1};
  assign b_sum = {1'b0, b0} + {1'b0, b1};

  always_comb begin
    push_blk.pal[0] = c0;
    push_blk.pal[1] = c1;
    if (four) begin
      push_blk.pal[2] = {r2[4:0], g2[5:0], b2[4:0]};
      push_blk.pal[3] = {r3[4:0], g3[5:0], b3[4:0]};
    end else begin
      push_blk.pal[2] = {r_sum[5:1], g_sum[6:1], b_sum[5:1]};
      push_blk.pal[3] = '0;
    end
    push_blk.four = four;
    push_blk.idx  = in_block_word[63:32];
    push_blk.col  = col_r;
    push_blk.row  = row_r;
  end

  assign bw      = image_width_r[CFG_W-1:2];
  assign col_inc = {1'b0, col_r} + (COL_W + 1)'(1);
  assign row_inc = {1'b0, row_r} + (COL_W + 1)'(1);

  always_comb begin
    if (bw > BPR_LIM) begin
      bpr = BPR_LIM;
    end else if (bw == '0) begin
      bpr = (COL_W + 1)'(1);
    end else begin
      bpr = bw;
    end
    col_nxt = col_r;
    row_nxt = row_r;
    if (push) begin
      if (in_last_block) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc >= bpr) begin
        col_nxt = '0;
        row_nxt = (row_inc >= ROW_LIM) ? '0 : row_inc[COL_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= IMAGE_WIDTH_RST;
      col_r         <= '0;
      row_r         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        image_width_r <= cfg_image_width;
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// File: design/bc1_queue.sv
// ----------------------------------------------------------------------------
// BC1 block queue
// Two-entry queue of decoded palettes between front end and pixel sequencer.
// ----------------------------------------------------------------------------
module bc1_queue import bc1_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  blk_t    push_blk,
  input  logic    pop,
  output blk_t    head,
  output q_stat_t q_stat
);

  blk_t       ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = cnt_r == 2'd2;
  assign q_stat.valid = cnt_r != 2'd0;
  assign head         = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_blk;
    end
  end

endmodule

// File: design/bc1_back.sv
// ----------------------------------------------------------------------------
// BC1 pixel sequencer
// Walks the sixteen indices of the head block, one pixel per beat, into a
// registered result stage.
// ----------------------------------------------------------------------------
module bc1_back import bc1_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  blk_t               head,
  input  q_stat_t            q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COLOR_W-1:0] out_pixel_color,
  output logic [COORD_W-1:0] out_pixel_x,
  output logic [COORD_W-1:0] out_pixel_y,
  output logic               out_transparent,
  output logic               out_last_pixel
);

  logic               out_valid_r;
  logic [3:0]         pix_r;
  logic               adv;
  logic [1:0]         sel;
  logic               clear;
  logic [COLOR_W-1:0] color_r;
  logic [COORD_W-1:0] x_r, y_r;
  logic               transp_r, last_r;

  assign adv   = q_stat.valid && (!out_valid_r || !out_stall);
  assign pop   = adv && (pix_r == PIX_LAST);
  assign sel   = head.idx[{pix_r, 1'b0} +: 2];
  assign clear = !head.four && (sel == SEL_CLEAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pix_r       <= '0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
        pix_r       <= pix_r + 4'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      color_r  <= clear ? '0 : head.pal[sel];
      x_r      <= {head.col, pix_r[1:0]};
      y_r      <= {head.row, pix_r[3:2]};
      transp_r <= clear;
      last_r   <= pix_r == PIX_LAST;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_color = color_r;
  assign out_pixel_x     = x_r;
  assign out_pixel_y     = y_r;
  assign out_transparent = transp_r;
  assign out_last_pixel  = last_r;

endmodule

// File: design/bc1_block_decoder.sv
// ----------------------------------------------------------------------------
// BC1 block decoder
// Decodes 64-bit BC1 blocks into sixteen RGB565 pixels with image coordinates.
//
//   channel  direction  handshake            beat carries
//   in_      input      in_valid / in_stall   block word, last-block flag
//   out_     output     out_valid / out_stall pixel colour, x, y, flags
//   cfg_     input      cfg_valid / cfg_ready image width
//
// The pixel sequencer emits one pixel per cycle while a block is queued and the output is not stalled.
// A block enters the queue in the cycle it is accepted; its first pixel
// is registered into the result stage once it is at the queue head and that stage is free.
// Reset is synchronous; the image width returns to four and the position to
// the origin. A two-entry queue lets the front take blocks while the output
// stalls; in_stall rises only when the queue is full.
// ----------------------------------------------------------------------------
`include "bc1_block_decoder_defines.svh"

module bc1_block_decoder import bc1_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        in_block_word,
  input  logic               in_last_block,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COLOR_W-1:0] out_pixel_color,
  output logic [COORD_W-1:0] out_pixel_x,
  output logic [COORD_W-1:0] out_pixel_y,
  output logic               out_transparent,
  output logic               out_last_pixel,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_image_width
);

  q_stat_t q_stat;
  logic    push, pop;
  blk_t    push_blk, head;

  bc1_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_block_word   (in_block_word),
    .in_last_block   (in_last_block),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_image_width (cfg_image_width),
    .q_stat          (q_stat),
    .push            (push),
    .push_blk        (push_blk)
  );

  bc1_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_blk (push_blk),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  bc1_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_color (out_pixel_color),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_transparent (out_transparent),
    .out_last_pixel  (out_last_pixel)
  );

  `BC1_CHECK_NOW(a_last_corner, out_valid && out_last_pixel, out_pixel_x[1:0] == 2'b11 && out_pixel_y[1:0] == 2'b11, "last pixel not at tile corner")
  `BC1_CHECK_NOW(a_transp_black, out_valid && out_transparent, out_pixel_color == '0, "transparent pixel not black")
  `BC1_CHECK_NEXT(a_push_queued, in_valid && !in_stall, q_stat.valid, "accepted block missing from queue")

endmodule

// File: tb/bc1_pixel_checker.sv
// ----------------------------------------------------------------------------
// BC1 block decoder pixel checker
// Watches the block, pixel and width channels of the decoder. Each block beat
// is expanded into its sixteen expected pixels, with palette, transparency and
// tile position tracked here. Each pixel beat is compared field by field with
// the oldest expected pixel. A failure count and the number of pixels still
// awaited are passed to the testbench top.
// ----------------------------------------------------------------------------
module bc1_pixel_checker import bc1_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [63:0]        in_block_word,
  input  logic               in_last_block,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [COLOR_W-1:0] out_pixel_color,
  input  logic [COORD_W-1:0] out_pixel_x,
  input  logic [COORD_W-1:0] out_pixel_y,
  input  logic               out_transparent,
  input  logic               out_last_pixel,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_image_width,
  output int                 mismatch_count,
  output int                 pixels_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               transparent;
    logic               last;
  } pixel_beat_t;

  pixel_beat_t      expected_pixels[$];
  logic [CFG_W-1:0] image_width;
  logic [COL_W-1:0] block_col;
  logic [COL_W-1:0] block_row;

  initial begin
    mismatch_count = 0;
    pixels_pending = 0;
  end

  function automatic logic [COLOR_W-1:0] blend565(input logic [15:0] a, input logic [15:0] b,
                                                  input int wa, input int wb, input int dv);
    int r;
    int g;
    int bl;
    r  = (wa * int'(a[15:11]) + wb * int'(b[15:11])) / dv;
    g  = (wa * int'(a[10:5])  + wb * int'(b[10:5]))  / dv;
    bl = (wa * int'(a[4:0])   + wb * int'(b[4:0]))   / dv;
    return {r[4:0], g[5:0], bl[4:0]};
  endfunction

  task automatic decode_block(input logic [63:0] word, input logic last_blk);
    logic [15:0]        c0;
    logic [15:0]        c1;
    logic [COLOR_W-1:0] palette [4];
    logic               four;
    logic [1:0]         sel;
    pixel_beat_t        pix;
    int                 blocks_wide;
    c0 = word[15:0];
    c1 = word[31:16];
    four = c0 > c1;
    palette[0] = c0;
    palette[1] = c1;
    if (four) begin
      palette[2] = blend565(c0, c1, 2, 1, 3);
      palette[3] = blend565(c0, c1, 1, 2, 3);
    end else begin
      palette[2] = blend565(c0, c1, 1, 1, 2);
      palette[3] = '0;
    end
    for (int z = 0; z < 16; z++) begin
      sel = word[32 + 2 * z +: 2];
      pix.transparent = !four && sel == SEL_CLEAR;
      pix.color = pix.transparent ? '0 : palette[sel];
      pix.x = {block_col, 2'(z)};
      pix.y = {block_row, 2'(z >> 2)};
      pix.last = 4'(z) == PIX_LAST;
      expected_pixels.push_back(pix);
    end
    blocks_wide = int'(image_width >> 2);
    if (blocks_wide > BPR_LIM_I) blocks_wide = BPR_LIM_I;
    if (blocks_wide < 1) blocks_wide = 1;
    if (last_blk) begin
      block_col = '0;
      block_row = '0;
    end else if (int'(block_col) + 1 >= blocks_wide) begin
      block_col = '0;
      block_row = (int'(block_row) + 1 >= ROW_LIM_I) ? '0 : block_row + 1'b1;
    end else begin
      block_col = block_col + 1'b1;
    end
  endtask

  // sample in the second half of the cycle: these are the beats of the coming edge
  always @(negedge clk) begin
    pixel_beat_t got;
    pixel_beat_t want;
    if (!rst_n) begin
      expected_pixels.delete();
      image_width = IMAGE_WIDTH_RST;
      block_col = '0;
      block_row = '0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_pixel_color, out_pixel_x, out_pixel_y, out_transparent, out_last_pixel};
        if (expected_pixels.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected pixel colour %h x %0d y %0d transp %b last %b",
                     $time, got.color, got.x, got.y, got.transparent, got.last);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10) begin
              $display("%0t: pixel mismatch, expected colour %h x %0d y %0d transp %b last %b",
                       $time, want.color, want.x, want.y, want.transparent, want.last);
              $display("%0t: pixel mismatch, got colour %h x %0d y %0d transp %b last %b",
                       $time, got.color, got.x, got.y, got.transparent, got.last);
            end
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) decode_block(in_block_word, in_last_block);
      if (cfg_valid && cfg_ready) image_width = cfg_image_width;
    end
    pixels_pending = expected_pixels.size();
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// BC1 block decoder testbench
// Drives directed BC1 blocks covering both palette modes, every index and the
// colour extremes, then random blocks over a range of image widths, including
// widths below four, not a multiple of four, saturating, and a change that
// leaves the position beyond the row. A short run at one block per row
// advances the block row on every block. The sender works in bursts, the
// receiver stalls on its own pattern; the pixel checker predicts and compares
// every beat.
// ----------------------------------------------------------------------------
module tb_top import bc1_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT      = 600000;
  localparam int RANDOM_PHASES    = 8;
  localparam int PHASE_BLOCKS     = 36;
  localparam int ROW_SWEEP_BLOCKS = 20;
  localparam int SETTLE_CYCLES    = 24;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_e;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [63:0]        in_block_word = '0;
  logic               in_last_block = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COLOR_W-1:0] out_pixel_color;
  logic [COORD_W-1:0] out_pixel_x;
  logic [COORD_W-1:0] out_pixel_y;
  logic               out_transparent;
  logic               out_last_pixel;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_image_width = IMAGE_WIDTH_RST;
  int                 mismatch_count;
  int                 pixels_pending;

  stall_mode_e stall_mode = STALL_LIGHT;
  int          stall_left = 0;
  int          cycle_count = 0;
  int          burst_left = 1;
  bit          gaps_on = 1'b1;

  bc1_block_decoder dut (.*);

  bc1_pixel_checker pixel_checker (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      case (stall_mode)
        STALL_NONE: begin
          out_stall <= 1'b0;
          stall_left <= 8;
        end
        STALL_LIGHT: begin
          out_stall <= !out_stall;
          stall_left <= out_stall ? $urandom_range(0, 9) : $urandom_range(0, 2);
        end
        default: begin
          out_stall <= !out_stall;
          stall_left <= out_stall ? $urandom_range(0, 3) : $urandom_range(0, 11);
        end
      endcase
    end
  end

  function automatic logic [63:0] random_block_word();
    logic [63:0] word;
    word = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: word[31:16] = word[15:0];
      1: if (word[15:0] <= word[31:16]) word[31:0] = {word[15:0], word[31:16]};
      default: ;
    endcase
    return word;
  endfunction

  task automatic send_block(input logic [63:0] word, input logic last_blk);
    logic took;
    int   gap;
    in_valid <= 1'b1;
    in_block_word <= word;
    in_last_block <= last_blk;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pixels_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input logic [CFG_W-1:0] width);
    logic took;
    cfg_valid <= 1'b1;
    cfg_image_width <= width;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [63:0]      directed_words [14];
    logic [CFG_W-1:0] width;
    int               pause_at;
    directed_words = '{
      64'hE4E4_E4E4_0000_FFFF, 64'hE4E4_E4E4_FFFF_0000, 64'hFFFF_FFFF_1234_1234,
      64'h1B1B_1B1B_1233_1234, 64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
      64'h5555_5555_07E0_F800, 64'hAAAA_AAAA_001F_F800, 64'hAAAA_AAAA_F800_001F,
      64'hFFFF_FFFF_0000_FFFF, 64'h0000_0000_FFFF_0000, 64'hE4E4_E4E4_F81F_07E0,
      64'h1B1B_1B1B_0001_FFFE, 64'h0123_4567_89AB_CDEF
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_words[i]) send_block(directed_words[i], i == 5 || i == 13);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: width = 13'h1FFF;
        1: width = 13'd8;
        2: width = 13'd13;
        3: width = 13'd0;
        4: width = 13'd4096;
        5: width = 13'd3;
        6: width = CFG_W'($urandom_range(2, 16) * 4);
        default: width = CFG_W'($urandom_range(0, 8191));
      endcase
      write_width(width);
      stall_mode <= stall_mode_e'($urandom_range(0, 2));
      gaps_on = $urandom_range(0, 3) != 0;
      pause_at = $urandom_range(5, PHASE_BLOCKS - 5);
      for (int n = 0; n < PHASE_BLOCKS; n++) begin
        if (n == pause_at) drain();
        send_block(random_block_word(), $urandom_range(0, 15) == 0);
      end
      drain();
    end

    // one block per row: advance the block row on every block
    write_width(IMAGE_WIDTH_RST);
    stall_mode <= STALL_NONE;
    gaps_on = 1'b0;
    for (int n = 0; n < ROW_SWEEP_BLOCKS; n++) send_block(random_block_word(), 1'b0);
    drain();

    if (mismatch_count == 0 && pixels_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
